// File: rtl/dspm_pkg.sv
// Shared types, constants and modular helpers for the divisor-sum unit.
`default_nettype none
package dspm_pkg;

    localparam int IN_BITS   = 32;
    localparam int OUT_BITS  = 14;
    localparam int MOD_BITS  = 14;
    localparam int MCNT_BITS = 4;
    localparam logic [MOD_BITS-1:0] SUM_MOD = 14'd9901;
    // Fermat inverse exponent: modulus minus two
    localparam logic [MOD_BITS-1:0] INV_EXP = 14'd9899;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_START,
        OP_DIV_TAKE,
        OP_NEXT_I,
        OP_PRIME_I,
        OP_PRIME_A,
        OP_RED_E1,
        OP_POW_NUM,
        OP_POW_INV,
        OP_MUL_NUM,
        OP_MUL_ACC_RED,
        OP_MUL_ACC_F,
        OP_SET_ACC,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic early;
        logic sq_le;
        logic a_gt1;
        logic rem_zero;
        logic flag;
        logic red_one;
    } t_status;

    // One shift-add step of a modular multiply: (2r + b*x) mod SUM_MOD
    function automatic logic [MOD_BITS-1:0] mm_step(input logic [MOD_BITS-1:0] r,
                                                    input logic [MOD_BITS-1:0] x,
                                                    input logic b);
        logic [MOD_BITS:0] t;
        logic [MOD_BITS:0] u;
        t = {r, 1'b0};
        if (t >= {1'b0, SUM_MOD}) t = t - {1'b0, SUM_MOD};
        u = t + (b ? {1'b0, x} : {(MOD_BITS+1){1'b0}});
        if (u >= {1'b0, SUM_MOD}) u = u - {1'b0, SUM_MOD};
        return u[MOD_BITS-1:0];
    endfunction

    // One bit of a serial reduction: (2r + b) mod SUM_MOD
    function automatic logic [MOD_BITS-1:0] red_step(input logic [MOD_BITS-1:0] r,
                                                     input logic b);
        logic [MOD_BITS:0] t;
        t = {r, b};
        if (t >= {1'b0, SUM_MOD}) t = t - {1'b0, SUM_MOD};
        return t[MOD_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/dspm_ifs.sv
// Valid/ready channel interfaces for operand input and result output.
`default_nettype none
interface dspm_in_if;
    logic                          valid;
    logic                          ready;
    logic [dspm_pkg::IN_BITS-1:0]  base_value;
    logic [dspm_pkg::IN_BITS-1:0]  power_value;
    modport source (output valid, output base_value, output power_value, input ready);
    modport sink   (input valid, input base_value, input power_value, output ready);
endinterface

interface dspm_out_if;
    logic                          valid;
    logic                          ready;
    logic [dspm_pkg::OUT_BITS-1:0] divisor_sum;
    modport source (output valid, output divisor_sum, input ready);
    modport sink   (input valid, input divisor_sum, output ready);
endinterface
`default_nettype wire

// File: rtl/dspm_dpath.sv
// Datapath: trial divider, serial reducer, power engine and modular multiplier.
`default_nettype none
module dspm_dpath #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire dspm_pkg::t_cmd                  i_cmd,
    input  wire logic [dspm_pkg::IN_BITS-1:0]    i_base,
    input  wire logic [dspm_pkg::IN_BITS-1:0]    i_power,
    output dspm_pkg::t_status                    o_st,
    output logic [dspm_pkg::OUT_BITS-1:0]        o_sum
);

    localparam int MB        = dspm_pkg::MOD_BITS;
    localparam int I_BITS    = (VALUE_BITS + 1) / 2 + 1;
    localparam int ISQ_BITS  = 2 * I_BITS;
    localparam int EXP_BITS  = VALUE_BITS + 6;
    localparam int DCNT_BITS = $clog2(VALUE_BITS + 1);
    localparam int RCNT_BITS = $clog2(EXP_BITS + 1);
    localparam int CB        = dspm_pkg::MCNT_BITS;

    // operand and loop registers
    logic [VALUE_BITS-1:0] r_a, r_b;
    logic [I_BITS-1:0]     r_i;
    logic [ISQ_BITS-1:0]   r_isq;
    logic [EXP_BITS-1:0]   r_exp;
    logic                  r_flag;
    logic [MB-1:0]         r_acc, r_pm, r_num, r_sum;

    // divider
    logic [VALUE_BITS-1:0] r_dq;
    logic [I_BITS-1:0]     r_dr;
    logic [DCNT_BITS-1:0]  r_dcnt;
    logic [I_BITS:0]       w_rsh;
    logic                  w_qbit;

    // reducer
    logic [EXP_BITS-1:0]   r_rsrc;
    logic [MB-1:0]         r_red;
    logic [RCNT_BITS-1:0]  r_rcnt;

    // power engine
    logic [MB-1:0]         r_pacc, r_psq, r_pyb, r_tacc, r_tsq;
    logic [EXP_BITS-1:0]   r_pexp;
    logic [CB-1:0]         r_pk;
    logic [MB-1:0]         w_tacc, w_tsq;

    // multiplier
    logic [MB-1:0]         r_mx, r_my, r_mr;
    logic [CB-1:0]         r_mcnt;
    logic                  r_mbusy;

    logic [MB-1:0]         w_pm_dec, w_pow_dec;

    assign w_rsh  = {r_dr, r_dq[VALUE_BITS-1]};
    assign w_qbit = (w_rsh >= {1'b0, r_i});
    assign w_tacc = dspm_pkg::mm_step(r_tacc, r_pacc, r_pyb[MB-1]);
    assign w_tsq  = dspm_pkg::mm_step(r_tsq, r_psq, r_pyb[MB-1]);
    assign w_pm_dec  = (r_pm == '0) ? dspm_pkg::SUM_MOD - MB'(1) : r_pm - MB'(1);
    assign w_pow_dec = (r_pacc == '0) ? dspm_pkg::SUM_MOD - MB'(1) : r_pacc - MB'(1);

    // control counters of the serial units
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt  <= '0;
            r_rcnt  <= '0;
            r_pexp  <= '0;
            r_pk    <= '0;
            r_mcnt  <= '0;
            r_mbusy <= 1'b0;
        end else begin
            if (i_cmd.op == dspm_pkg::OP_DIV_START || i_cmd.op == dspm_pkg::OP_DIV_TAKE) begin
                r_dcnt <= DCNT_BITS'(VALUE_BITS);
            end else if (r_dcnt != '0) begin
                r_dcnt <= r_dcnt - DCNT_BITS'(1);
            end

            if (i_cmd.op == dspm_pkg::OP_PRIME_I || i_cmd.op == dspm_pkg::OP_PRIME_A
                || i_cmd.op == dspm_pkg::OP_RED_E1) begin
                r_rcnt <= RCNT_BITS'(EXP_BITS);
            end else if (r_rcnt != '0) begin
                r_rcnt <= r_rcnt - RCNT_BITS'(1);
            end

            if (i_cmd.op == dspm_pkg::OP_POW_NUM) begin
                r_pexp <= r_exp + EXP_BITS'(1);
                r_pk   <= '0;
            end else if (i_cmd.op == dspm_pkg::OP_POW_INV) begin
                r_pexp <= EXP_BITS'(dspm_pkg::INV_EXP);
                r_pk   <= '0;
            end else if (r_pexp != '0) begin
                if (r_pk == CB'(MB - 1)) begin
                    r_pk   <= '0;
                    r_pexp <= r_pexp >> 1;
                end else begin
                    r_pk <= r_pk + CB'(1);
                end
            end

            if (i_cmd.op == dspm_pkg::OP_MUL_NUM || i_cmd.op == dspm_pkg::OP_MUL_ACC_RED
                || i_cmd.op == dspm_pkg::OP_MUL_ACC_F) begin
                r_mcnt  <= '0;
                r_mbusy <= 1'b1;
            end else if (r_mbusy) begin
                r_mcnt <= r_mcnt + CB'(1);
                if (r_mcnt == CB'(MB - 1)) r_mbusy <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        // divider step: one quotient bit per cycle
        if (r_dcnt != '0) begin
            r_dr <= w_qbit ? I_BITS'(w_rsh - {1'b0, r_i}) : w_rsh[I_BITS-1:0];
            r_dq <= {r_dq[VALUE_BITS-2:0], w_qbit};
        end
        // reducer step: one source bit per cycle
        if (r_rcnt != '0) begin
            r_red  <= dspm_pkg::red_step(r_red, r_rsrc[EXP_BITS-1]);
            r_rsrc <= r_rsrc << 1;
        end
        // power engine: square and conditional multiply in parallel
        if (r_pexp != '0) begin
            if (r_pk == CB'(MB - 1)) begin
                if (r_pexp[0]) r_pacc <= w_tacc;
                r_psq  <= w_tsq;
                r_pyb  <= w_tsq;
                r_tacc <= '0;
                r_tsq  <= '0;
            end else begin
                r_tacc <= w_tacc;
                r_tsq  <= w_tsq;
                r_pyb  <= r_pyb << 1;
            end
        end
        // multiplier step
        if (r_mbusy) begin
            r_mr <= dspm_pkg::mm_step(r_mr, r_mx, r_my[MB-1]);
            r_my <= r_my << 1;
        end

        case (i_cmd.op)
            dspm_pkg::OP_LOAD: begin
                r_a    <= i_base[VALUE_BITS-1:0];
                r_b    <= i_power[VALUE_BITS-1:0];
                r_i    <= I_BITS'(2);
                r_isq  <= ISQ_BITS'(4);
                r_exp  <= '0;
                r_flag <= 1'b0;
                r_acc  <= (i_power[VALUE_BITS-1:0] != '0 && i_base[VALUE_BITS-1:0] == '0)
                          ? '0 : MB'(1);
            end
            dspm_pkg::OP_DIV_START: begin
                r_dq <= r_a;
                r_dr <= '0;
            end
            dspm_pkg::OP_DIV_TAKE: begin
                r_a    <= r_dq;
                r_exp  <= r_exp + EXP_BITS'(r_b);
                r_flag <= 1'b1;
                r_dr   <= '0;
            end
            dspm_pkg::OP_NEXT_I: begin
                r_i    <= r_i + I_BITS'(1);
                r_isq  <= r_isq + ISQ_BITS'({r_i, 1'b1});
                r_exp  <= '0;
                r_flag <= 1'b0;
            end
            dspm_pkg::OP_PRIME_I: begin
                r_rsrc <= EXP_BITS'(r_i);
                r_red  <= '0;
            end
            dspm_pkg::OP_PRIME_A: begin
                r_rsrc <= EXP_BITS'(r_a);
                r_red  <= '0;
                r_exp  <= EXP_BITS'(r_b);
            end
            dspm_pkg::OP_RED_E1: begin
                r_rsrc <= r_exp + EXP_BITS'(1);
                r_red  <= '0;
            end
            dspm_pkg::OP_POW_NUM: begin
                r_pm   <= r_red;
                r_pacc <= MB'(1);
                r_psq  <= r_red;
                r_pyb  <= r_red;
                r_tacc <= '0;
                r_tsq  <= '0;
            end
            dspm_pkg::OP_POW_INV: begin
                r_num  <= w_pow_dec;
                r_pacc <= MB'(1);
                r_psq  <= w_pm_dec;
                r_pyb  <= w_pm_dec;
                r_tacc <= '0;
                r_tsq  <= '0;
            end
            dspm_pkg::OP_MUL_NUM: begin
                r_mx <= r_num;
                r_my <= r_pacc;
                r_mr <= '0;
            end
            dspm_pkg::OP_MUL_ACC_RED: begin
                r_mx <= r_acc;
                r_my <= r_red;
                r_mr <= '0;
            end
            dspm_pkg::OP_MUL_ACC_F: begin
                r_mx <= r_acc;
                r_my <= r_mr;
                r_mr <= '0;
            end
            dspm_pkg::OP_SET_ACC: r_acc <= r_mr;
            dspm_pkg::OP_EMIT:    r_sum <= r_acc;
            default: ;
        endcase
    end

    // status toward the controller
    assign o_st.busy     = (r_dcnt != '0) || (r_rcnt != '0) || (r_pexp != '0) || r_mbusy;
    assign o_st.early    = (r_a == '0) || (r_b == '0);
    assign o_st.sq_le    = (r_isq <= ISQ_BITS'(r_a));
    assign o_st.a_gt1    = (r_a > VALUE_BITS'(1));
    assign o_st.rem_zero = (r_dr == '0);
    assign o_st.flag     = r_flag;
    assign o_st.red_one  = (r_red == MB'(1));
    assign o_sum         = r_sum;

endmodule
`default_nettype wire

// File: rtl/dspm_ctrl.sv
// Controller: sequences trial division, series factors and result handoff.
`default_nettype none
module dspm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire dspm_pkg::t_status i_st,
    output dspm_pkg::t_cmd         o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_SPECIAL = 12'b0000_0000_0010,
        S_TEST    = 12'b0000_0000_0100,
        S_DIV     = 12'b0000_0000_1000,
        S_RED_P   = 12'b0000_0001_0000,
        S_RED_E   = 12'b0000_0010_0000,
        S_POW_NUM = 12'b0000_0100_0000,
        S_POW_INV = 12'b0000_1000_0000,
        S_MUL_F   = 12'b0001_0000_0000,
        S_MUL_ACC = 12'b0010_0000_0000,
        S_ADV     = 12'b0100_0000_0000,
        S_FINISH  = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_final, n_final;
    logic   r_out_valid, n_out_valid;

    // next state and command
    always_comb begin
        n_state     = r_state;
        n_final     = r_final;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.op    = dspm_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = dspm_pkg::OP_LOAD;
                    n_state  = S_SPECIAL;
                end
            end
            S_SPECIAL: n_state = i_st.early ? S_FINISH : S_TEST;
            S_TEST: begin
                if (i_st.sq_le) begin
                    o_cmd.op = dspm_pkg::OP_DIV_START;
                    n_state  = S_DIV;
                end else if (i_st.a_gt1) begin
                    o_cmd.op = dspm_pkg::OP_PRIME_A;
                    n_final  = 1'b1;
                    n_state  = S_RED_P;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_DIV: begin
                if (!i_st.busy) begin
                    if (i_st.rem_zero) begin
                        o_cmd.op = dspm_pkg::OP_DIV_TAKE;
                    end else if (i_st.flag) begin
                        o_cmd.op = dspm_pkg::OP_PRIME_I;
                        n_final  = 1'b0;
                        n_state  = S_RED_P;
                    end else begin
                        o_cmd.op = dspm_pkg::OP_NEXT_I;
                        n_state  = S_TEST;
                    end
                end
            end
            S_RED_P: begin
                if (!i_st.busy) begin
                    if (i_st.red_one) begin
                        o_cmd.op = dspm_pkg::OP_RED_E1;
                        n_state  = S_RED_E;
                    end else begin
                        o_cmd.op = dspm_pkg::OP_POW_NUM;
                        n_state  = S_POW_NUM;
                    end
                end
            end
            S_RED_E: begin
                if (!i_st.busy) begin
                    o_cmd.op = dspm_pkg::OP_MUL_ACC_RED;
                    n_state  = S_MUL_ACC;
                end
            end
            S_POW_NUM: begin
                if (!i_st.busy) begin
                    o_cmd.op = dspm_pkg::OP_POW_INV;
                    n_state  = S_POW_INV;
                end
            end
            S_POW_INV: begin
                if (!i_st.busy) begin
                    o_cmd.op = dspm_pkg::OP_MUL_NUM;
                    n_state  = S_MUL_F;
                end
            end
            S_MUL_F: begin
                if (!i_st.busy) begin
                    o_cmd.op = dspm_pkg::OP_MUL_ACC_F;
                    n_state  = S_MUL_ACC;
                end
            end
            S_MUL_ACC: begin
                if (!i_st.busy) begin
                    o_cmd.op = dspm_pkg::OP_SET_ACC;
                    n_state  = S_ADV;
                end
            end
            S_ADV: begin
                if (r_final) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.op = dspm_pkg::OP_NEXT_I;
                    n_state  = S_TEST;
                end
            end
            S_FINISH: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = dspm_pkg::OP_EMIT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_final     <= n_final;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// File: rtl/divisor_sum_of_power_mod_prime_unit.sv
// Top level: sum of divisors of A^B modulo 9901.
//
// Operands (base_value, power_value) arrive as one beat on the i_in channel;
// each beat yields one beat on o_out carrying divisor_sum = sigma(A^B) mod 9901.
// Only the low VALUE_BITS bits of each operand are used.
// One operand is worked on at a time. The cost is set by the trial divider,
// a restoring divider giving one quotient bit per cycle, run on each
// candidate divisor i with i*i <= A, so a prime A near 2^32 tries about
// 65536 candidates. Each prime power found adds a serial reduction of the
// prime, then either two modular powers and two serial multiplies, or, when
// the prime is 1 mod 9901, a reduction of the exponent plus one and one
// multiply. B = 0 or A = 0 goes from the special-case check to the result.
// A finished result sits in the output register; the next operand beat is
// taken while it waits. If the receiver stalls, a second finished result
// holds inside the unit until the register frees.
// Reset (i_rst_n low, synchronous) empties the output register and returns
// the unit to idle; a pending result is dropped and not emitted afterwards.
`default_nettype none
module divisor_sum_of_power_mod_prime_unit #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dspm_in_if.sink    i_in,
    dspm_out_if.source o_out
);

    dspm_pkg::t_cmd    w_cmd;
    dspm_pkg::t_status w_st;

    dspm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_st        (w_st),
        .o_cmd       (w_cmd)
    );

    dspm_dpath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_base  (i_in.base_value),
        .i_power (i_in.power_value),
        .o_st    (w_st),
        .o_sum   (o_out.divisor_sum)
    );

    // accept operands only while no serial unit is running
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !w_st.busy)
        else $error("operand accepted while a unit is busy");

    // a new result is always a reduced residue
    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> (o_out.divisor_sum < dspm_pkg::SUM_MOD))
        else $error("result out of range");

    // units are started only when the datapath is quiet
    a_start_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == dspm_pkg::OP_DIV_START || w_cmd.op == dspm_pkg::OP_POW_NUM
         || w_cmd.op == dspm_pkg::OP_MUL_NUM) |-> !w_st.busy)
        else $error("unit started while busy");

    // emitting a result makes the output valid next cycle
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == dspm_pkg::OP_EMIT) |=> o_out.valid)
        else $error("emitted result not presented");

endmodule
`default_nettype wire
